// ===== rtl/resource_pool_dispatch_with_undo_top_macros.svh =====
`ifndef RESOURCE_POOL_DISPATCH_WITH_UNDO_TOP_MACROS_SVH
`define RESOURCE_POOL_DISPATCH_WITH_UNDO_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define RPD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpd assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define RPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpd assertion failed");

`endif

// ===== rtl/rpd_pkg.sv =====
`default_nettype none

package rpd_pkg;

  localparam int FIELD_ID_W  = 16;
  localparam int FIELD_CNT_W = 7;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_UNDO     = 2'd2,
    OP_SPARE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED        = 3'd0,
    ST_DUPLICATE    = 3'd1,
    ST_DISPATCHED   = 3'd2,
    ST_NONE_AVAIL   = 3'd3,
    ST_RETURNED     = 3'd4,
    ST_NOTHING_UNDO = 3'd5,
    ST_FULL         = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_FINISH
  } state_t;

  typedef struct packed {
    status_t                  status;
    logic [FIELD_ID_W-1:0]    rid;
    logic [FIELD_CNT_W-1:0]   avail;
    logic [FIELD_CNT_W-1:0]   disp;
    logic [FIELD_CNT_W-1:0]   fleet;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/rpd_chan_if.sv =====
`default_nettype none

interface rpd_req_if import rpd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            operation;
  logic [FIELD_ID_W-1:0] ship_id;

  modport source (output valid, output operation, output ship_id, input ready);
  modport sink (input valid, input operation, input ship_id, output ready);
endinterface

interface rpd_rsp_if import rpd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [2:0]             status_code;
  logic [FIELD_ID_W-1:0]  result_id;
  logic [FIELD_CNT_W-1:0] available_count;
  logic [FIELD_CNT_W-1:0] dispatched_count;
  logic [FIELD_CNT_W-1:0] fleet_count;

  modport source (output valid, output status_code, output result_id,
                  output available_count, output dispatched_count,
                  output fleet_count, input ready);
  modport sink (input valid, input status_code, input result_id,
                input available_count, input dispatched_count,
                input fleet_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/rpd_ram.sv =====
`default_nettype none

module rpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/rpd_ctrl.sv =====
`default_nettype none

module rpd_ctrl import rpd_pkg::*; #(
  parameter int POOL_DEPTH = 64,
  parameter int ID_BITS    = 16,
  localparam int AW        = $clog2(POOL_DEPTH),
  localparam int CW        = $clog2(POOL_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire op_t                op_in,
  input  wire logic [ID_BITS-1:0] id_in,
  output logic                    idle,
  input  wire logic               out_free,
  output logic                    done,
  output res_t                    res,
  // registry memory
  output logic                    reg_we,
  output logic [AW-1:0]           reg_waddr,
  output logic [ID_BITS-1:0]      reg_wdata,
  output logic [AW-1:0]           reg_raddr,
  input  wire logic [ID_BITS-1:0] reg_rdata,
  // fifo ring in the low half, undo stack in the high half
  output logic                    pool_we,
  output logic [AW:0]             pool_waddr,
  output logic [ID_BITS-1:0]      pool_wdata,
  output logic [AW:0]             pool_raddr,
  input  wire logic [ID_BITS-1:0] pool_rdata
);

  localparam logic [CW-1:0] FULL_CNT = CW'(POOL_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(POOL_DEPTH - 1);

  state_t             state, state_next;
  op_t                op;
  logic [ID_BITS-1:0] id;
  logic [CW-1:0]      issue_idx;
  logic               cmp_valid;
  logic               found;
  logic [CW-1:0]      reg_count, fifo_count, undo_count;
  logic [AW-1:0]      head, tail;

  logic               issue;
  logic [AW-1:0]      head_inc, tail_inc;
  logic [CW-1:0]      undo_dec;
  logic               do_add, do_disp, do_ret;
  status_t            status;
  logic [ID_BITS-1:0] rid;
  logic [CW-1:0]      reg_count_next, fifo_count_next, undo_count_next;
  logic [ID_BITS+FIELD_ID_W-1:0] rid_ext;
  logic [CW+FIELD_CNT_W-1:0]     avail_ext, disp_ext, fleet_ext;

  assign issue    = (state == S_SCAN) && (issue_idx < reg_count);
  assign head_inc = (head == LAST_IDX) ? '0 : head + AW'(1);
  assign tail_inc = (tail == LAST_IDX) ? '0 : tail + AW'(1);
  assign undo_dec = undo_count - CW'(1);

  // outcome of the item, valid in S_FINISH
  always_comb begin
    do_add  = 1'b0;
    do_disp = 1'b0;
    do_ret  = 1'b0;
    rid     = '0;
    unique case (op)
      OP_REGISTER: begin
        if (found) begin
          status = ST_DUPLICATE;
        end else if (reg_count >= FULL_CNT || fifo_count >= FULL_CNT) begin
          status = ST_FULL;
        end else begin
          status = ST_ADDED;
          do_add = 1'b1;
          rid    = id;
        end
      end
      OP_DISPATCH: begin
        if (fifo_count == '0 || undo_count >= FULL_CNT) begin
          status = ST_NONE_AVAIL;
        end else begin
          status  = ST_DISPATCHED;
          do_disp = 1'b1;
          rid     = pool_rdata;
        end
      end
      OP_UNDO: begin
        if (undo_count == '0) begin
          status = ST_NOTHING_UNDO;
        end else if (fifo_count >= FULL_CNT) begin
          status = ST_FULL;
        end else begin
          status = ST_RETURNED;
          do_ret = 1'b1;
          rid    = pool_rdata;
        end
      end
      default: begin
        status = ST_NOTHING_UNDO;
      end
    endcase

    reg_count_next  = reg_count + CW'(do_add);
    fifo_count_next = fifo_count + CW'(do_add) + CW'(do_ret) - CW'(do_disp);
    undo_count_next = undo_count + CW'(do_disp) - CW'(do_ret);
  end

  assign rid_ext   = {{FIELD_ID_W{1'b0}}, rid};
  assign avail_ext = {{FIELD_CNT_W{1'b0}}, fifo_count_next};
  assign disp_ext  = {{FIELD_CNT_W{1'b0}}, undo_count_next};
  assign fleet_ext = {{FIELD_CNT_W{1'b0}}, reg_count_next};

  always_comb begin
    res.status = status;
    res.rid    = rid_ext[FIELD_ID_W-1:0];
    res.avail  = avail_ext[FIELD_CNT_W-1:0];
    res.disp   = disp_ext[FIELD_CNT_W-1:0];
    res.fleet  = fleet_ext[FIELD_CNT_W-1:0];
  end

  // memory ports
  assign reg_raddr  = issue_idx[AW-1:0];
  assign reg_we     = done && do_add;
  assign reg_waddr  = reg_count[AW-1:0];
  assign reg_wdata  = id;
  assign pool_raddr = (op == OP_DISPATCH) ? {1'b0, head} : {1'b1, undo_dec[AW-1:0]};
  assign pool_we    = done && (do_add || do_disp || do_ret);
  assign pool_waddr = do_disp ? {1'b1, undo_count[AW-1:0]} : {1'b0, tail};
  assign pool_wdata = do_add ? id : pool_rdata;

  always_comb begin
    state_next = state;
    idle       = 1'b0;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          state_next = (op_in == OP_REGISTER) ? S_SCAN : S_READ;
        end
      end
      S_SCAN: begin
        if (!issue && !cmp_valid) begin
          state_next = S_FINISH;
        end
      end
      S_READ: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_count  <= '0;
      fifo_count <= '0;
      undo_count <= '0;
      head       <= '0;
      tail       <= '0;
      cmp_valid  <= 1'b0;
      found      <= 1'b0;
      issue_idx  <= '0;
    end else begin
      if (idle && start) begin
        issue_idx <= '0;
        cmp_valid <= 1'b0;
        found     <= 1'b0;
      end else if (state == S_SCAN) begin
        if (issue) begin
          issue_idx <= issue_idx + CW'(1);
        end
        cmp_valid <= issue;
        if (cmp_valid && reg_rdata == id) begin
          found <= 1'b1;
        end
      end
      if (done) begin
        reg_count  <= reg_count_next;
        fifo_count <= fifo_count_next;
        undo_count <= undo_count_next;
        if (do_add || do_ret) begin
          tail <= tail_inc;
        end
        if (do_disp) begin
          head <= head_inc;
        end
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (idle && start) begin
      op <= op_in;
      id <= id_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/resource_pool_dispatch_with_undo_top.sv =====
// flow: register passes S_SCAN, which reads every registry entry, and then S_FINISH;
// dispatch and undo pass S_READ and then S_FINISH, which waits for a free output register
// one item at a time: no new item is taken until the last one has finished
// the duplicate check reads the registry memory one entry per cycle
// reset: synchronous rst clears counts, ring pointers, sequencer and the result valid flag
// memories are not cleared; only entries already written are ever used
`default_nettype none

module resource_pool_dispatch_with_undo_top import rpd_pkg::*; #(
  parameter int POOL_DEPTH = 64,
  parameter int ID_BITS    = 16
) (
  input wire logic clk,
  input wire logic rst,
  rpd_req_if.sink  req,
  rpd_rsp_if.source rsp
);

  localparam int AW = $clog2(POOL_DEPTH);

  // identifier as stored: low ID_BITS bits of ship_id, zero-extended when wider
  logic [ID_BITS+FIELD_ID_W-1:0] ship_ext;
  logic [ID_BITS-1:0]            id_in;

  logic   idle, done, out_free, accept;
  res_t   res;

  logic               reg_we;
  logic [AW-1:0]      reg_waddr, reg_raddr;
  logic [ID_BITS-1:0] reg_wdata, reg_rdata;
  logic               pool_we;
  logic [AW:0]        pool_waddr, pool_raddr;
  logic [ID_BITS-1:0] pool_wdata, pool_rdata;

  // result register
  logic out_valid;
  res_t out_res;

  assign ship_ext = {{ID_BITS{1'b0}}, req.ship_id};
  assign id_in    = ship_ext[ID_BITS-1:0];

  // one item in flight; a finished result may wait in the output register
  // no item is taken while rst is high
  assign req.ready = idle && !rst;
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  rpd_ctrl #(
    .POOL_DEPTH (POOL_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .op_in      (op_t'(req.operation)),
    .id_in      (id_in),
    .idle       (idle),
    .out_free   (out_free),
    .done       (done),
    .res        (res),
    .reg_we     (reg_we),
    .reg_waddr  (reg_waddr),
    .reg_wdata  (reg_wdata),
    .reg_raddr  (reg_raddr),
    .reg_rdata  (reg_rdata),
    .pool_we    (pool_we),
    .pool_waddr (pool_waddr),
    .pool_wdata (pool_wdata),
    .pool_raddr (pool_raddr),
    .pool_rdata (pool_rdata)
  );

  // registry: identifiers in registration order, scanned for duplicates
  rpd_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (2 ** AW)
  ) u_registry_ram (
    .clk   (clk),
    .we    (reg_we),
    .waddr (reg_waddr),
    .wdata (reg_wdata),
    .raddr (reg_raddr),
    .rdata (reg_rdata)
  );

  // available ring and undo stack share one memory, split by the top address bit
  rpd_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (2 ** (AW + 1))
  ) u_pool_ram (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_waddr),
    .wdata (pool_wdata),
    .raddr (pool_raddr),
    .rdata (pool_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_res <= res;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.status_code      = out_res.status;
  assign rsp.result_id        = out_res.rid;
  assign rsp.available_count  = out_res.avail;
  assign rsp.dispatched_count = out_res.disp;
  assign rsp.fleet_count      = out_res.fleet;

  `include "resource_pool_dispatch_with_undo_top_macros.svh"

  // every registered id is either waiting in the ring or on the undo stack
  `RPD_ASSERT_IMPL(a_counts_balance, rsp.valid,
    FIELD_CNT_W'(rsp.available_count + rsp.dispatched_count) == rsp.fleet_count)

  // a result is only produced while an item is in flight
  `RPD_ASSERT_IMPL(a_done_busy, done, !idle)

  // a finished item is loaded into the output register and shown next cycle
  `RPD_ASSERT_NEXT(a_done_shows, done, rsp.valid && rsp.status_code == $past(res.status))

  // an add always leaves something in the registry
  `RPD_ASSERT_IMPL(a_added_fleet, rsp.valid && rsp.status_code == ST_ADDED,
    rsp.fleet_count != '0 || POOL_DEPTH >= 128)

endmodule

`default_nettype wire
